/* sv/cct_pkg.sv */
package cct_pkg;

  localparam int SampleW  = 32;
  localparam int ExtW     = 64;
  localparam int ClkW     = 10;
  localparam int SecW     = 45;
  localparam int PartW    = 10;
  localparam int TotalW   = 55;
  localparam int DivW     = 30;
  localparam int StepW    = 6;
  localparam int QDepth   = 2;
  localparam int QPtrW    = 1;
  localparam int QCntW    = 2;
  localparam int OutDataW = 184;

  localparam logic [ClkW-1:0]  CLK_MHZ_RESET  = 10'd168;
  localparam logic [DivW-1:0]  US_PER_S       = 30'd1000000;
  localparam logic [DivW-1:0]  US_PER_MS      = 30'd1000;
  localparam logic [StepW-1:0] STEP_LAST_EXT  = 6'd63;
  localparam logic [StepW-1:0] STEP_LAST_PART = 6'd9;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV_CLK,
    B_DIV_SEC,
    B_DIV_MS,
    B_DIV_US,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic [SecW-1:0]   whole_seconds;
    logic [PartW-1:0]  milliseconds;
    logic [PartW-1:0]  microseconds;
    logic [TotalW-1:0] total_microseconds;
    logic [ExtW-1:0]   extended_count;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* sv/cct_front.sv */
module cct_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [cct_pkg::SampleW-1:0]  in_tdata,
  input  cct_pkg::q_status_t           q_status,
  output logic                         push,
  output logic [cct_pkg::ExtW-1:0]     push_data
);
  import cct_pkg::*;

  logic [SampleW-1:0] prev_r, prev_nxt;
  logic [SampleW-1:0] wrap_r, wrap_nxt;

  assign in_tready = !q_status.full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    prev_nxt = prev_r;
    wrap_nxt = wrap_r;
    if (in_tdata < prev_r) begin
      wrap_nxt = wrap_r + 32'd1;
    end
    if (push) begin
      prev_nxt = in_tdata;
    end else begin
      wrap_nxt = wrap_r;
    end
  end

  assign push_data = {wrap_nxt, in_tdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      wrap_r <= '0;
    end else begin
      prev_r <= prev_nxt;
      wrap_r <= wrap_nxt;
    end
  end

endmodule

/* sv/cct_queue.sv */
module cct_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic [cct_pkg::ExtW-1:0]  push_data,
  input  logic                      pop,
  output logic [cct_pkg::ExtW-1:0]  pop_data,
  output cct_pkg::q_status_t        status
);
  import cct_pkg::*;

  logic [ExtW-1:0]  mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;

  assign status.full  = (cnt_r == QCntW'(QDepth));
  assign status.empty = (cnt_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* sv/cct_back.sv */
module cct_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [cct_pkg::ClkW-1:0]  clock_mhz,
  input  cct_pkg::q_status_t        q_status,
  input  logic [cct_pkg::ExtW-1:0]  pop_data,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cct_pkg::result_t          result
);
  import cct_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [ExtW-1:0]   quo_r;
  logic [DivW-1:0]   rem_r;
  logic [StepW-1:0]  step_r;
  logic [ExtW-1:0]   ext_r;
  logic [TotalW-1:0] tot_r;
  logic [SecW-1:0]   sec_r;
  logic [PartW-1:0]  ms_r;
  logic [DivW-1:0]   per_s_r;
  logic [DivW-1:0]   per_ms_r;
  logic              out_valid_r;
  result_t           result_r;

  logic              start, zero_clk, div_en, last, load_out;
  logic [DivW-1:0]   clk_ext;
  logic [DivW-1:0]   divisor;
  logic [DivW:0]     trial, diff;
  logic              ge;
  logic [ExtW-1:0]   quo_step;
  logic [DivW-1:0]   rem_step;

  // one restoring step per cycle; every divisor scales with the clock
  always_comb begin
    clk_ext = {{(DivW-ClkW){1'b0}}, clock_mhz};
    case (state_r)
      B_DIV_SEC: divisor = per_s_r;
      B_DIV_MS:  divisor = per_ms_r;
      default:   divisor = clk_ext;
    endcase
    trial    = {rem_r, quo_r[ExtW-1]};
    diff     = trial - {1'b0, divisor};
    ge       = (trial >= {1'b0, divisor});
    rem_step = ge ? diff[DivW-1:0] : trial[DivW-1:0];
    quo_step = {quo_r[ExtW-2:0], ge};
  end

  always_comb begin
    start    = (state_r == B_IDLE) && !q_status.empty;
    zero_clk = (clock_mhz == '0);
    div_en   = state_r inside {B_DIV_CLK, B_DIV_SEC, B_DIV_MS, B_DIV_US};
    case (state_r)
      B_DIV_MS, B_DIV_US: last = (step_r == STEP_LAST_PART);
      default:            last = (step_r == STEP_LAST_EXT);
    endcase
    pop      = start;
    load_out = (state_r == B_DONE) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (start) begin
          state_nxt = zero_clk ? B_DONE : B_DIV_CLK;
        end
      end
      B_DIV_CLK: begin
        if (last) state_nxt = B_DIV_SEC;
      end
      B_DIV_SEC: begin
        if (last) state_nxt = B_DIV_MS;
      end
      B_DIV_MS: begin
        if (last) state_nxt = B_DIV_US;
      end
      B_DIV_US: begin
        if (last) state_nxt = B_DONE;
      end
      B_DONE: begin
        if (load_out) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // ms and us quotients are below 1024, so those passes start 10 bits in
  always_ff @(posedge clk) begin
    if (start) begin
      ext_r    <= pop_data;
      quo_r    <= zero_clk ? '0 : pop_data;
      rem_r    <= '0;
      step_r   <= '0;
      tot_r    <= '0;
      sec_r    <= '0;
      ms_r     <= '0;
      per_s_r  <= clk_ext * US_PER_S;
      per_ms_r <= clk_ext * US_PER_MS;
    end else if (div_en) begin
      step_r <= last ? '0 : step_r + 1'b1;
      if (last && state_r == B_DIV_CLK) begin
        tot_r <= quo_step[TotalW-1:0];
        quo_r <= ext_r;
        rem_r <= '0;
      end else if (last && state_r == B_DIV_SEC) begin
        sec_r <= quo_step[SecW-1:0];
        quo_r <= {rem_step[PartW-1:0], {(ExtW-PartW){1'b0}}};
        rem_r <= rem_step >> PartW;
      end else if (last && state_r == B_DIV_MS) begin
        ms_r  <= quo_step[PartW-1:0];
        quo_r <= {rem_step[PartW-1:0], {(ExtW-PartW){1'b0}}};
        rem_r <= rem_step >> PartW;
      end else begin
        quo_r <= quo_step;
        rem_r <= rem_step;
      end
    end
    if (load_out) begin
      result_r.whole_seconds      <= sec_r;
      result_r.milliseconds       <= ms_r;
      result_r.microseconds       <= quo_r[PartW-1:0];
      result_r.total_microseconds <= tot_r;
      result_r.extended_count     <= ext_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

/* sv/cycle_count_time_splitter.sv */
// Cycle counter timestamp splitter.
// in_*  : stream of 32-bit samples of a free-running cycle counter.
// out_* : one result word per sample: whole seconds, ms, us, total us and
//         the 64-bit extended count (wrap count above the sample).
// cfg_* : write of the core clock in MHz (10 bits); always ready. Write it
//         only while no sample is in flight. Zero gives zero time fields.
// The front end tracks wraps and accepts a sample per cycle, while the queue
// is not full, into a 2-word queue; the back end runs one shared restoring
// divider, one quotient bit a cycle: 64 steps by the clock, 64 by cycles per
// second, 10 by cycles per ms and 10 by the clock. A sample passes from the
// queue through these four passes (none with a zero clock) to the result
// register behind out_tvalid, and the next starts once that result is loaded.
// Reset clears the wrap state, empties the queue, clears out_tvalid, and
// loads 168 MHz. A stalled receiver holds the result; the back end finishes
// the next sample and waits, and in_tready falls once the queue is full.
module cycle_count_time_splitter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cct_pkg::SampleW-1:0]       in_tdata,   // [31:0] counter_sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [44:0] whole_seconds, [54:45] milliseconds, [64:55] microseconds,
  // [119:65] total_microseconds, [183:120] extended_count
  output logic [cct_pkg::OutDataW-1:0]      out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cct_pkg::ClkW-1:0]          cfg_data
);
  import cct_pkg::*;

  logic [ClkW-1:0] clk_mhz_r;
  logic            push, pop;
  logic [ExtW-1:0] push_data, pop_data;
  q_status_t       q_status;
  result_t         result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_mhz_r <= CLK_MHZ_RESET;
    end else if (cfg_valid) begin
      clk_mhz_r <= cfg_data;
    end
  end

  cct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  cct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  cct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clock_mhz (clk_mhz_r),
    .q_status  (q_status),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .result    (result)
  );

  assign out_tdata = {result.extended_count, result.total_microseconds,
                      result.microseconds, result.milliseconds, result.whole_seconds};

endmodule

/* verif/testbench.sv */
module testbench;
  import cct_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int RandomSamples = 700;
  localparam int HoldOffCycles = 1500;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [SampleW-1:0] value;
    bit                typed;
    result_t           want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [SampleW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [ClkW-1:0]     cfg_data;

  // timing model state
  logic [ClkW-1:0]    clock_mhz_now;
  logic [SampleW-1:0] tracked_sample;
  logic [SampleW-1:0] tracked_wraps;

  result_t     pending_splits[$];
  stim_row_t   directed_rows[$];
  int          mismatches = 0;
  int          strays = 0;
  int          words_out = 0;
  int          cycles = 0;
  int          burst_left;
  bit          no_gaps;
  logic [SampleW-1:0] last_sent;

  cycle_count_time_splitter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic result_t split_sample(input logic [SampleW-1:0] sample);
    logic [63:0] ext;
    logic [63:0] per_s;
    logic [63:0] per_ms;
    logic [63:0] rest;
    logic [63:0] secs;
    logic [63:0] msecs;
    logic [63:0] usecs;
    logic [63:0] total;
    result_t     r;
    if (sample < tracked_sample) tracked_wraps = tracked_wraps + 1'b1;
    tracked_sample = sample;
    ext = {tracked_wraps, sample};
    secs = '0;
    msecs = '0;
    usecs = '0;
    total = '0;
    if (clock_mhz_now != '0) begin
      per_s = 64'(clock_mhz_now) * 64'd1000000;
      per_ms = 64'(clock_mhz_now) * 64'd1000;
      secs = ext / per_s;
      rest = ext - secs * per_s;
      msecs = rest / per_ms;
      rest = rest - msecs * per_ms;
      usecs = rest / 64'(clock_mhz_now);
      total = secs * 64'd1000000 + msecs * 64'd1000 + usecs;
    end
    r.whole_seconds = secs[SecW-1:0];
    r.milliseconds = msecs[PartW-1:0];
    r.microseconds = usecs[PartW-1:0];
    r.total_microseconds = total[TotalW-1:0];
    r.extended_count = ext;
    return r;
  endfunction

  function automatic stim_row_t mk_row(input row_kind_t kind, input logic [SampleW-1:0] value,
                                       input bit typed, input logic [SecW-1:0] secs,
                                       input logic [PartW-1:0] msecs,
                                       input logic [PartW-1:0] usecs,
                                       input logic [TotalW-1:0] total,
                                       input logic [ExtW-1:0] ext);
    stim_row_t r;
    r.kind = kind;
    r.value = value;
    r.typed = typed;
    r.want.whole_seconds = secs;
    r.want.milliseconds = msecs;
    r.want.microseconds = usecs;
    r.want.total_microseconds = total;
    r.want.extended_count = ext;
    return r;
  endfunction

  task automatic offer_sample(input logic [SampleW-1:0] sample, input bit typed,
                              input result_t want);
    int      gap;
    result_t r;
    if (!no_gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= sample;
    do @(posedge clk); while (!in_tready);
    r = split_sample(sample);
    if (typed) r = want;
    pending_splits.push_back(r);
    last_sent = sample;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_splits.size() != 0) @(posedge clk);
  endtask

  task automatic write_clock(input logic [ClkW-1:0] mhz);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= mhz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    clock_mhz_now = mhz;
  endtask

  function automatic logic [SampleW-1:0] next_sample(input logic [SampleW-1:0] prev);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return prev + $urandom_range(0, 1 << 24);
    if (pick < 75) return prev + $urandom;
    if (pick < 85) return prev;
    if (pick < 95) return (prev == 0) ? '0 : $urandom_range(0, prev - 1);
    return $urandom;
  endfunction

  function automatic logic [ClkW-1:0] pick_clock();
    case ($urandom_range(0, 9))
      0: return 10'd1;
      1: return 10'd1000;
      2: return 10'd1023;
      3: return 10'd0;
      4: return ClkW'($urandom_range(0, 1023));
      default: return ClkW'($urandom_range(1, 1000));
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    cycles++;
    if (cycles == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      words_out++;
      got.whole_seconds = out_tdata[44:0];
      got.milliseconds = out_tdata[54:45];
      got.microseconds = out_tdata[64:55];
      got.total_microseconds = out_tdata[119:65];
      got.extended_count = out_tdata[183:120];
      if (pending_splits.size() == 0) begin
        strays++;
        if (strays + mismatches <= 10) $display("unexpected word: ext %h", got.extended_count);
      end else begin
        want = pending_splits.pop_front();
        if (got.whole_seconds !== want.whole_seconds ||
            got.milliseconds !== want.milliseconds ||
            got.microseconds !== want.microseconds ||
            got.total_microseconds !== want.total_microseconds ||
            got.extended_count !== want.extended_count) begin
          mismatches++;
          if (strays + mismatches <= 10) begin
            $display("mismatch exp s=%0d ms=%0d us=%0d tot=%0d ext=%h",
                     want.whole_seconds, want.milliseconds, want.microseconds,
                     want.total_microseconds, want.extended_count);
            $display("         got s=%0d ms=%0d us=%0d tot=%0d ext=%h",
                     got.whole_seconds, got.milliseconds, got.microseconds,
                     got.total_microseconds, got.extended_count);
          end
        end
      end
    end
  end

  // receiver: own stall pattern, one long hold-off to back the block up
  initial begin
    bit held;
    int n;
    held = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && words_out >= 80) begin
        held = 1'b1;
        out_tready <= 1'b0;
        n = HoldOffCycles;
      end else if ($urandom_range(0, 9) < 2) begin
        out_tready <= 1'b1;
        n = $urandom_range(200, 800);
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
        n = $urandom_range(1, 40);
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    int sent;
    int phase_len;
    result_t none;
    none = '0;
    burst_left = 0;
    no_gaps = 1'b1;
    last_sent = '0;
    clock_mhz_now = CLK_MHZ_RESET;
    tracked_sample = '0;
    tracked_wraps = '0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;

    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'd0, 1, 0, 0, 0, 0, 64'd0));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'd0, 1, 0, 0, 0, 0, 64'd0));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'd168, 1, 0, 0, 1, 1, 64'd168));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'd168000, 1, 0, 1, 0, 1000, 64'd168000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'd168000000, 1, 1, 0, 0, 1000000,
                                   64'd168000000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'd0, 0, 0, 0, 0, 0, 0));
    // zero clock: time fields stay zero, wraps still tracked
    directed_rows.push_back(mk_row(ROW_CFG, 32'd0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'd5, 1, 0, 0, 0, 0, 64'h1_0000_0005));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'd4, 1, 0, 0, 0, 0, 64'h2_0000_0004));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'd4, 1, 0, 0, 0, 0, 64'h2_0000_0004));
    directed_rows.push_back(mk_row(ROW_CFG, 32'd1000, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'h5555_5555, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ROW_CFG, 32'd1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'hAAAA_AAAA, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'd1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ROW_CFG, 32'd1023, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ROW_CFG, 32'd168, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 32'd0, 0, 0, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) write_clock(directed_rows[i].value[ClkW-1:0]);
      else offer_sample(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
    end

    sent = 0;
    while (sent < RandomSamples) begin
      write_clock(pick_clock());
      no_gaps = ($urandom_range(0, 4) == 0);
      burst_left = 0;
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        offer_sample(next_sample(last_sent), 1'b0, none);
        sent++;
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && strays == 0 && pending_splits.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
